FILE: rtl/fbc_pkg.sv
// fbc_pkg: shared types and constants for the frustum box cull block.
// Used by fbc_dot_unit, frustum_box_cull and the testbench; depends on nothing.
package fbc_pkg;

    // Port width of every value field (Q16.16)
    localparam int unsigned FIELD_W = 32;

    // Matrix store geometry: column*4+row
    localparam int unsigned MAT_DEPTH = 16;

    // Input beat modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Component codes issued to the dot unit; the last one carries the distance
    localparam logic [1:0] COMP_X    = 2'd0;
    localparam logic [1:0] COMP_Y    = 2'd1;
    localparam logic [1:0] COMP_Z    = 2'd2;
    localparam logic [1:0] COMP_DIST = 2'd3;

    // Rows 0..2 of the matrix are added to or subtracted from row 3
    localparam logic [1:0] ROW_W = 2'd3;

    // Six planes, indexed {row, minus}
    localparam logic [2:0] LAST_PLANE = 3'd5;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_WAIT  = 4'b1000
    } t_state;

    // Tag that travels with one plane component through the dot unit
    typedef struct packed {
        logic       valid;
        logic [1:0] comp;
        logic       minus;
        logic       last;
        logic       nz;
    } t_op_tag;

    // Per-plane verdict from the dot unit
    typedef struct packed {
        logic valid;
        logic reject;
        logic last;
    } t_plane_stat;

endpackage

FILE: rtl/fbc_ram.sv
// fbc_ram: generic register-file RAM, one write port, two registered read ports.
// No dependencies.
module fbc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read ports
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

FILE: rtl/fbc_dot_unit.sv
// fbc_dot_unit: shared plane evaluation unit, one component per beat.
// Forms the normal component, picks the box vertex, multiplies, accumulates.
// Depends on fbc_pkg.
module fbc_dot_unit
    import fbc_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_op_tag                i_tag,
    input  logic [VALUE_WIDTH-1:0] i_elem_a,
    input  logic [VALUE_WIDTH-1:0] i_elem_b,
    input  logic [VALUE_WIDTH-1:0] i_coord_min,
    input  logic [VALUE_WIDTH-1:0] i_coord_max,
    output t_plane_stat            o_stat
);

    localparam int unsigned VW    = VALUE_WIDTH;
    localparam int unsigned ACC_W = 2 * VW + 3;

    // Stage 1: normal component and vertex selection
    logic signed [VW:0]   w_n;
    logic signed [VW:0]   r_n;
    logic signed [VW-1:0] r_v;
    t_op_tag              r_tag2;

    always_comb begin
        if (i_tag.minus) begin
            w_n = $signed({i_elem_a[VW-1], i_elem_a}) - $signed({i_elem_b[VW-1], i_elem_b});
        end else begin
            w_n = $signed({i_elem_a[VW-1], i_elem_a}) + $signed({i_elem_b[VW-1], i_elem_b});
        end
    end

    always_ff @(posedge i_clk) begin
        r_n <= w_n;
        // positive vertex: max where the normal component is >= 0
        r_v <= w_n[VW] ? $signed(i_coord_min) : $signed(i_coord_max);
        if (!i_rst_n) begin
            r_tag2 <= '0;
        end else begin
            r_tag2.valid <= i_tag.valid;
            r_tag2.comp  <= i_tag.comp;
            r_tag2.minus <= i_tag.minus;
            r_tag2.last  <= i_tag.last;
            r_tag2.nz    <= (i_tag.comp != COMP_DIST) && (|w_n);
        end
    end

    // Stage 2: multiply, or scale the distance to Q.32
    logic signed [2*VW:0]   w_prod;
    logic signed [ACC_W-1:0] w_dist;
    logic signed [ACC_W-1:0] r_prod;
    t_op_tag                 r_tag3;

    assign w_prod = r_n * r_v;
    assign w_dist = ACC_W'(r_n) <<< 16;

    always_ff @(posedge i_clk) begin
        r_prod <= (r_tag2.comp == COMP_DIST) ? w_dist : ACC_W'(w_prod);
        if (!i_rst_n) begin
            r_tag3 <= '0;
        end else begin
            r_tag3 <= r_tag2;
        end
    end

    // Stage 3: accumulate; the distance beat closes the plane
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] w_sum;
    logic                    r_nz;
    logic                    w_nz;

    assign w_sum = ((r_tag3.comp == COMP_X) ? ACC_W'(0) : r_acc) + r_prod;
    assign w_nz  = ((r_tag3.comp == COMP_X) ? 1'b0 : r_nz) | r_tag3.nz;

    always_ff @(posedge i_clk) begin
        if (r_tag3.valid) begin
            r_acc <= w_sum;
            r_nz  <= w_nz;
        end
    end

    // A plane with an all-zero normal never rejects
    always_comb begin
        o_stat.valid  = r_tag3.valid && (r_tag3.comp == COMP_DIST);
        o_stat.reject = w_nz && w_sum[ACC_W-1];
        o_stat.last   = r_tag3.last;
    end

endmodule

FILE: rtl/frustum_box_cull.sv
// frustum_box_cull: view-frustum rejection of axis-aligned boxes, top level.
// Load beat: one matrix element is written; the block stays idle and ready.
// Query beat: 24 component beats (6 planes x 4) through the shared dot unit;
// ready again once the result is posted to the output register; queries do not overlap.
// Reset (i_rst_n low, synchronous) empties the matrix to zero and idles the block.
// Depends on fbc_pkg, fbc_ram and fbc_dot_unit.
module frustum_box_cull
    import fbc_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_mode,
    input  logic [3:0]         i_elem_index,
    input  logic [FIELD_W-1:0] i_elem_value,
    input  logic [FIELD_W-1:0] i_min_x,
    input  logic [FIELD_W-1:0] i_min_y,
    input  logic [FIELD_W-1:0] i_min_z,
    input  logic [FIELD_W-1:0] i_max_x,
    input  logic [FIELD_W-1:0] i_max_y,
    input  logic [FIELD_W-1:0] i_max_z,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_visible
);

    localparam int unsigned VW = VALUE_WIDTH;

    t_state r_state, n_state;

    logic w_accept;
    logic w_load;
    logic w_query;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_load     = w_accept && (i_mode == MODE_LOAD);
    assign w_query    = w_accept && (i_mode == MODE_QUERY);

    // Box capture
    logic [VW-1:0] r_bmin [3];
    logic [VW-1:0] r_bmax [3];

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_bmin[0] <= i_min_x[VW-1:0];
            r_bmin[1] <= i_min_y[VW-1:0];
            r_bmin[2] <= i_min_z[VW-1:0];
            r_bmax[0] <= i_max_x[VW-1:0];
            r_bmax[1] <= i_max_y[VW-1:0];
            r_bmax[2] <= i_max_z[VW-1:0];
        end
    end

    // Plane / component sequencer
    logic [2:0] r_plane;
    logic [1:0] r_comp;
    logic       w_issue;
    logic       w_issue_last;

    assign w_issue      = (r_state == S_RUN);
    assign w_issue_last = (r_plane == LAST_PLANE) && (r_comp == COMP_DIST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
            r_comp  <= COMP_X;
        end else if (w_query) begin
            r_plane <= '0;
            r_comp  <= COMP_X;
        end else if (w_issue) begin
            r_comp <= r_comp + 2'd1;
            if (r_comp == COMP_DIST) begin
                r_plane <= r_plane + 3'd1;
            end
        end
    end

    // Matrix store: row 3 element and row r element of the current column
    logic [3:0]    w_addr_a;
    logic [3:0]    w_addr_b;
    logic [VW-1:0] w_rdata_a;
    logic [VW-1:0] w_rdata_b;
    logic [15:0]   r_valid;
    logic          r_va;
    logic          r_vb;

    assign w_addr_a = {r_comp, ROW_W};
    assign w_addr_b = {r_comp, r_plane[2:1]};

    fbc_ram #(
        .WIDTH (VW),
        .DEPTH (MAT_DEPTH)
    ) u_mat (
        .i_clk     (i_clk),
        .i_we      (w_load),
        .i_waddr   (i_elem_index),
        .i_wdata   (i_elem_value[VW-1:0]),
        .i_raddr_a (w_addr_a),
        .i_raddr_b (w_addr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    // Unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_load) begin
            r_valid[i_elem_index] <= 1'b1;
        end
        r_va <= r_valid[w_addr_a];
        r_vb <= r_valid[w_addr_b];
    end

    // Tag aligned with the registered read data
    t_op_tag r_tag1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
        end else begin
            r_tag1.valid <= w_issue;
            r_tag1.comp  <= r_comp;
            r_tag1.minus <= r_plane[0];
            r_tag1.last  <= (r_plane == LAST_PLANE);
            r_tag1.nz    <= 1'b0;
        end
    end

    // Box coordinates for the component in stage 1
    logic [VW-1:0] w_cmin;
    logic [VW-1:0] w_cmax;

    always_comb begin
        case (r_tag1.comp)
            COMP_X: begin
                w_cmin = r_bmin[0];
                w_cmax = r_bmax[0];
            end
            COMP_Y: begin
                w_cmin = r_bmin[1];
                w_cmax = r_bmax[1];
            end
            COMP_Z: begin
                w_cmin = r_bmin[2];
                w_cmax = r_bmax[2];
            end
            default: begin
                w_cmin = r_bmin[0];
                w_cmax = r_bmax[0];
            end
        endcase
    end

    t_plane_stat w_stat;

    fbc_dot_unit #(
        .VALUE_WIDTH (VW)
    ) u_dot (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tag       (r_tag1),
        .i_elem_a    (r_va ? w_rdata_a : '0),
        .i_elem_b    (r_vb ? w_rdata_b : '0),
        .i_coord_min (w_cmin),
        .i_coord_max (w_cmax),
        .o_stat      (w_stat)
    );

    // Verdict: visible unless some plane rejects
    logic r_vis;

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_vis <= 1'b1;
        end else if (w_stat.valid && w_stat.reject) begin
            r_vis <= 1'b0;
        end
    end

    // Output register
    logic w_post;

    assign w_post = (r_state == S_WAIT) && (!o_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_post) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
        if (w_post) begin
            o_visible <= r_vis;
        end
    end

    // State machine
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_query) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (w_issue_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_stat.valid && w_stat.last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_post) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTH
    // Plane verdicts only arrive while a query is in flight
    a_stat_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.valid |-> (r_state == S_RUN || r_state == S_DRAIN))
        else $error("plane verdict outside a query");

    // A query beat starts the sequencer at plane 0, component x
    a_query_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_query |=> (r_state == S_RUN && r_plane == 3'd0 && r_comp == COMP_X))
        else $error("query did not start the sequencer");

    // A result is posted only from the wait state
    a_post_from_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_WAIT))
        else $error("result posted outside the wait state");
`endif

endmodule

FILE: dv/tb_frustum_box_cull.sv
`timescale 1ns / 100ps
// tb_frustum_box_cull: self-checking testbench for the frustum box cull block.
// Sends matrix load and box query beats, predicts visibility, checks each result beat.
// Depends on fbc_pkg and the frustum_box_cull RTL.
module tb_frustum_box_cull;
    import fbc_pkg::*;

    localparam int unsigned VALUE_WIDTH = 32;
    localparam int QUERY_LATENCY = 28;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int ONE_Q         = 65536;   // 1.0 in Q16.16

    typedef logic [2:0][FIELD_W-1:0] t_box_corner;   // [0]=x [1]=y [2]=z

    typedef struct packed {
        logic               mode;
        logic [3:0]         idx;
        logic [FIELD_W-1:0] value;
        t_box_corner        lo;
        t_box_corner        hi;
    } t_cull_beat;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_mode = MODE_LOAD;
    logic [3:0]         i_elem_index = '0;
    logic [FIELD_W-1:0] i_elem_value = '0;
    logic [FIELD_W-1:0] i_min_x = '0;
    logic [FIELD_W-1:0] i_min_y = '0;
    logic [FIELD_W-1:0] i_min_z = '0;
    logic [FIELD_W-1:0] i_max_x = '0;
    logic [FIELD_W-1:0] i_max_y = '0;
    logic [FIELD_W-1:0] i_max_z = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic               o_visible;

    frustum_box_cull #(.VALUE_WIDTH(VALUE_WIDTH)) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_elem_index (i_elem_index),
        .i_elem_value (i_elem_value),
        .i_min_x      (i_min_x),
        .i_min_y      (i_min_y),
        .i_min_z      (i_min_z),
        .i_max_x      (i_max_x),
        .i_max_y      (i_max_y),
        .i_max_z      (i_max_z),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_visible    (o_visible)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the matrix and the queue of predicted verdicts
    logic [FIELD_W-1:0] shadow_matrix [MAT_DEPTH];
    logic               visible_q [$];
    int                 errors = 0;
    int                 cycles = 0;
    int                 beats_sent = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;

    initial begin
        for (int i = 0; i < MAT_DEPTH; i++) shadow_matrix[i] = '0;
    end

    // Low VALUE_WIDTH bits read as two's complement
    function automatic longint q_value(logic [FIELD_W-1:0] raw);
        longint t;
        t = longint'(raw);
        t = t << (64 - VALUE_WIDTH);
        return t >>> (64 - VALUE_WIDTH);
    endfunction

    function automatic longint mat_elem(int col, int row);
        return q_value(shadow_matrix[col*4 + row]);
    endfunction

    // Visibility of one box against the six planes of the shadow matrix
    function automatic logic predict_visible(t_cull_beat beat);
        longint              nrm [3];
        longint              plane_d;
        logic signed [127:0] acc;
        logic signed [127:0] term_n;
        logic signed [127:0] term_v;
        logic                flat;
        logic                minus;
        int                  row;
        for (int p = 0; p <= int'(LAST_PLANE); p++) begin
            row   = p / 2;
            minus = (p % 2) != 0;
            flat  = 1'b1;
            for (int c = 0; c < 3; c++) begin
                nrm[c] = minus ? mat_elem(c, ROW_W) - mat_elem(c, row)
                               : mat_elem(c, ROW_W) + mat_elem(c, row);
                if (nrm[c] != 0) flat = 1'b0;
            end
            plane_d = minus ? mat_elem(3, ROW_W) - mat_elem(3, row)
                            : mat_elem(3, ROW_W) + mat_elem(3, row);
            // a plane with no normal never culls
            if (!flat) begin
                acc = plane_d;
                acc = acc <<< 16;
                for (int c = 0; c < 3; c++) begin
                    term_n = nrm[c];
                    term_v = (nrm[c] >= 0) ? q_value(beat.hi[c]) : q_value(beat.lo[c]);
                    acc = acc + term_n * term_v;
                end
                if (acc < 0) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what);
        errors++;
        $display("MISMATCH cycle %0d: %s", cycles, what);
    endtask

    // Cycle count and watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("watchdog expired after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: random backpressure
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker: every accepted result beat against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (visible_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat, visible=%b", o_visible));
            end else if (o_visible !== visible_q[0]) begin
                report_mismatch($sformatf("visible=%b, predicted %b", o_visible, visible_q[0]));
                void'(visible_q.pop_front());
            end else begin
                void'(visible_q.pop_front());
            end
        end
    end

    // Send one input beat, with random idle cycles ahead of it
    task automatic send_beat(t_cull_beat beat);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= beat.mode;
        i_elem_index <= beat.idx;
        i_elem_value <= beat.value;
        i_min_x      <= beat.lo[0];
        i_min_y      <= beat.lo[1];
        i_min_z      <= beat.lo[2];
        i_max_x      <= beat.hi[0];
        i_max_y      <= beat.hi[1];
        i_max_z      <= beat.hi[2];
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        // beat accepted at this edge
        if (beat.mode == MODE_LOAD) shadow_matrix[beat.idx] = beat.value;
        else visible_q.push_back(predict_visible(beat));
        beats_sent++;
    endtask

    // Hold off the sender until every predicted result has been seen
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (visible_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_box_corner box3(int x, int y, int z);
        t_box_corner r;
        r[0] = x;
        r[1] = y;
        r[2] = z;
        return r;
    endfunction

    // Load beat; box fields carry junk
    function automatic t_cull_beat load_beat(logic [3:0] idx, logic [FIELD_W-1:0] val);
        t_cull_beat b;
        b.mode  = MODE_LOAD;
        b.idx   = idx;
        b.value = val;
        for (int c = 0; c < 3; c++) begin
            b.lo[c] = $urandom;
            b.hi[c] = $urandom;
        end
        return b;
    endfunction

    // Query beat; element fields carry junk
    function automatic t_cull_beat query_beat(t_box_corner lo, t_box_corner hi);
        t_cull_beat b;
        b.mode  = MODE_QUERY;
        b.idx   = 4'($urandom);
        b.value = $urandom;
        b.lo    = lo;
        b.hi    = hi;
        return b;
    endfunction

    function automatic logic [FIELD_W-1:0] corner_value();
        case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            default: return $urandom;
        endcase
    endfunction

    // Matrix element: often small, some zero, unit, moderate or anything
    function automatic logic [FIELD_W-1:0] rand_elem();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40) return int'($urandom_range(0, 4*ONE_Q)) - 2*ONE_Q;
        else if (sel < 60) return '0;
        else if (sel < 70) return $urandom_range(1) ? ONE_Q : -ONE_Q;
        else if (sel < 85) return int'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
        else return $urandom;
    endfunction

    task automatic make_box(output t_box_corner lo, output t_box_corner hi);
        int          sel;
        int          ctr;
        int          half;
        logic [FIELD_W-1:0] tmp;
        sel = $urandom_range(99);
        for (int c = 0; c < 3; c++) begin
            ctr  = int'($urandom_range(0, 8*ONE_Q)) - 4*ONE_Q;
            if (c == 2) ctr = 2*ctr;
            half = $urandom_range(0, 3*ONE_Q);
            lo[c] = ctr - half;
            hi[c] = ctr + half;
        end
        if (sel >= 60 && sel < 75) begin
            // inverted on some axes
            for (int c = 0; c < 3; c++) begin
                if ($urandom_range(1)) begin
                    tmp   = lo[c];
                    lo[c] = hi[c];
                    hi[c] = tmp;
                end
            end
        end else if (sel < 85 && sel >= 75) begin
            for (int c = 0; c < 3; c++) begin
                lo[c] = $urandom;
                hi[c] = $urandom;
            end
        end else if (sel < 92 && sel >= 85) begin
            for (int c = 0; c < 3; c++) begin
                lo[c] = corner_value();
                hi[c] = corner_value();
            end
        end else if (sel >= 92) begin
            hi = lo;
        end
    endtask

    task automatic send_random_query();
        t_box_corner lo;
        t_box_corner hi;
        make_box(lo, hi);
        send_beat(query_beat(lo, hi));
    endtask

    // Full reload with a perturbed orthographic or perspective matrix
    task automatic load_frustum();
        int tmpl [16];
        int step;
        int offs;
        int idx;
        int val;
        for (int i = 0; i < 16; i++) tmpl[i] = 0;
        tmpl[0] = $urandom_range(ONE_Q/4, 4*ONE_Q);
        tmpl[5] = $urandom_range(ONE_Q/4, 4*ONE_Q);
        if ($urandom_range(1)) begin
            tmpl[10] = -int'($urandom_range(ONE_Q, 2*ONE_Q));
            tmpl[14] = -int'($urandom_range(0, ONE_Q/2));
            tmpl[11] = -ONE_Q;
        end else begin
            tmpl[10] = $urandom_range(ONE_Q/8, 2*ONE_Q);
            if ($urandom_range(1)) tmpl[10] = -tmpl[10];
            for (int i = 12; i < 15; i++) tmpl[i] = int'($urandom_range(0, 2*ONE_Q)) - ONE_Q;
            tmpl[15] = ONE_Q;
        end
        step = 2*$urandom_range(7) + 1;
        offs = $urandom_range(15);
        for (int i = 0; i < 16; i++) begin
            idx = (i*step + offs) % 16;
            val = tmpl[idx];
            if ($urandom_range(1)) val = val + int'($urandom_range(0, ONE_Q/4)) - ONE_Q/8;
            send_beat(load_beat(4'(idx), val));
        end
    endtask

    task automatic load_random_matrix();
        for (int i = 0; i < 16; i++) send_beat(load_beat(4'(i), rand_elem()));
    endtask

    // Empty matrix: every plane has no normal, so every box is visible
    task automatic test_reset_matrix();
        send_beat(query_beat(box3(-ONE_Q, -ONE_Q, -ONE_Q), box3(ONE_Q, ONE_Q, ONE_Q)));
        send_beat(query_beat({3{32'h8000_0000}}, {3{32'h8000_0000}}));
    endtask

    // Planes with zero normals and negative distance still pass the box
    task automatic test_zero_normal();
        send_beat(load_beat(4'd15, -ONE_Q));
        send_beat(load_beat(4'd12, 5*ONE_Q));
        send_beat(query_beat(box3(0, 0, 0), box3(0, 0, 0)));
    endtask

    // Identity matrix: the frustum is the cube [-1,1]^3
    task automatic test_unit_cube();
        send_beat(load_beat(4'd12, '0));
        send_beat(load_beat(4'd0, ONE_Q));
        send_beat(load_beat(4'd5, ONE_Q));
        send_beat(load_beat(4'd10, ONE_Q));
        send_beat(load_beat(4'd15, ONE_Q));
        send_beat(query_beat(box3(-ONE_Q/2, -ONE_Q/2, -ONE_Q/2),
                             box3(ONE_Q/2, ONE_Q/2, ONE_Q/2)));
        send_beat(query_beat(box3(2*ONE_Q, 0, 0), box3(3*ONE_Q, 0, 0)));
        // touching the x = 1 face gives exactly zero: kept
        send_beat(query_beat(box3(ONE_Q, 0, 0), box3(2*ONE_Q, 0, 0)));
        // inverted boxes
        send_beat(query_beat(box3(ONE_Q/2, ONE_Q/2, ONE_Q/2),
                             box3(-ONE_Q/2, -ONE_Q/2, -ONE_Q/2)));
        send_beat(query_beat(box3(3*ONE_Q, 0, 0), box3(2*ONE_Q, 0, 0)));
    endtask

    // Extreme element and coordinate values
    task automatic test_extreme_values();
        send_beat(load_beat(4'd0, 32'h7FFF_FFFF));
        send_beat(load_beat(4'd3, 32'h8000_0000));
        send_beat(load_beat(4'd15, 32'h7FFF_FFFF));
        send_beat(load_beat(4'd14, 32'h8000_0000));
        send_beat(query_beat({3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}));
        send_beat(query_beat({3{32'h8000_0000}}, {3{32'h8000_0000}}));
        send_beat(query_beat({3{32'h7FFF_FFFF}}, {3{32'h7FFF_FFFF}}));
    endtask

    // Random frames: matrix updates followed by runs of queries
    task automatic test_random_traffic(int n_items, int idle_pct, int stall_pct);
        int target;
        int sel;
        int cnt;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = beats_sent + n_items;
        while (beats_sent < target) begin
            sel = $urandom_range(99);
            if (sel < 12) begin
                load_frustum();
            end else if (sel < 20) begin
                load_random_matrix();
            end else if (sel < 28) begin
                cnt = $urandom_range(1, 3);
                repeat (cnt) send_beat(load_beat(4'($urandom), rand_elem()));
            end else begin
                cnt = $urandom_range(1, 6);
                repeat (cnt) send_random_query();
            end
            if ($urandom_range(39) == 0) wait_results_drained();
        end
        wait_results_drained();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_matrix();
        test_zero_normal();
        test_unit_cube();
        test_extreme_values();
        wait_results_drained();

        test_random_traffic(450, 0, 0);
        test_random_traffic(450, 64, 0);
        test_random_traffic(450, 0, 64);
        test_random_traffic(450, 11, 11);

        wait_results_drained();
        repeat (2*QUERY_LATENCY) @(posedge i_clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: frustum_box_cull.f
rtl/fbc_pkg.sv
rtl/fbc_ram.sv
rtl/fbc_dot_unit.sv
rtl/frustum_box_cull.sv
dv/tb_frustum_box_cull.sv
